>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the stepper pulse sequencer.
// Depends on nothing; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define GSPS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define GSPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define GSPS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/gsps_pkg.sv
// Shared types, register codes and reset values of the stepper pulse sequencer.
// Depends on nothing; used by scoped names in every module of the block but gsps_fifo.
package gsps_pkg;

   // Register widths.
   localparam int MAX_STEPS_W = 15;
   localparam int HALF_W      = 16;
   localparam int BACK_OFF_W  = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_STEPS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_FAST   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_SLOW   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACK_OFF    = 2'd3;

   // Register reset values.
   localparam logic [MAX_STEPS_W-1:0] MAX_STEPS_RST = 15'd3840;
   localparam logic [HALF_W-1:0]      HALF_FAST_RST = 16'd500;
   localparam logic [HALF_W-1:0]      HALF_SLOW_RST = 16'd5000;
   localparam logic [BACK_OFF_W-1:0]  BACK_OFF_RST  = 8'd24;

   // Default queue depths (powers of two).
   localparam int CMD_DEPTH_DEF = 2;
   localparam int RSP_DEPTH_DEF = 4;

   // Input command codes.
   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_SET  = 2'd1;
   localparam logic [1:0] CMD_ZERO = 2'd2;

   // Classified operation handed from the front end to the back end.
   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_SET  = 2'd1,
      OP_ZERO = 2'd2,
      OP_NOP  = 2'd3
   } op_kind_type;

   typedef struct packed {
      op_kind_type            kind;
      logic [MAX_STEPS_W-1:0] target;
   } op_type;

   // Result item as queued towards the result port.
   typedef struct packed {
      logic                   step_level;
      logic                   dir_level;
      logic                   busy_res;
      logic                   zeroing;
      logic [MAX_STEPS_W-1:0] position;
   } rsp_type;

   // Configuration as seen by the front and back ends.
   typedef struct packed {
      logic [MAX_STEPS_W-1:0] max_steps;
      logic [HALF_W-1:0]      half_fast;
      logic [HALF_W-1:0]      half_slow;
      logic [BACK_OFF_W-1:0]  back_off;
   } cfg_type;

   // Zeroing sequence phases.
   typedef enum logic [3:0] {
      ZP_NONE = 4'b0001,
      ZP_FWD  = 4'b0010,
      ZP_BACK = 4'b0100,
      ZP_OFF  = 4'b1000
   } zero_phase_type;

endpackage

>>> rtl/gsps_fifo.sv
// Small first-in first-out queue of registers for the stepper pulse sequencer.
// Depends on nothing; DEPTH must be a power of two, at least two.
module gsps_fifo #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW:0] FULL_COUNT = (AW + 1)'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == FULL_COUNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   // Pointer and fill count update; pointers wrap on their own.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

>>> rtl/gsps_front.sv
// Front end of the stepper pulse sequencer: decodes commands and clamps targets.
// Depends on gsps_pkg.
module gsps_front (
   input  logic [1:0]                      cmd,
   input  logic signed [15:0]              target,
   input  logic [gsps_pkg::MAX_STEPS_W-1:0] max_steps,
   output gsps_pkg::op_type                op
);

   logic [gsps_pkg::MAX_STEPS_W-1:0] top;
   logic [gsps_pkg::MAX_STEPS_W-1:0] mag;

   // Highest legal position; a full scale of zero pins everything to zero.
   assign top = (max_steps != '0) ? max_steps - 1'b1 : '0;
   assign mag = target[gsps_pkg::MAX_STEPS_W-1:0];

   always_comb begin
      op.target = '0;
      unique case (cmd)
         gsps_pkg::CMD_TICK: op.kind = gsps_pkg::OP_TICK;
         gsps_pkg::CMD_SET:  op.kind = gsps_pkg::OP_SET;
         gsps_pkg::CMD_ZERO: op.kind = gsps_pkg::OP_ZERO;
         default:            op.kind = gsps_pkg::OP_NOP;
      endcase
      // Negative requests go to zero, large ones to the top of scale.
      if (target[15]) begin
         op.target = '0;
      end else if (mag > top) begin
         op.target = top;
      end else begin
         op.target = mag;
      end
   end

endmodule

>>> rtl/gsps_back.sv
// Back end of the stepper pulse sequencer: pulse timing, moves and zeroing.
// Depends on gsps_pkg; executes one classified operation per cycle while op_valid is high.
module gsps_back (
   input  logic              clock,
   input  logic              reset,
   input  gsps_pkg::cfg_type cfg,
   input  logic              op_valid,
   input  gsps_pkg::op_type  op,
   output gsps_pkg::rsp_type rsp
);

   localparam int MW = gsps_pkg::MAX_STEPS_W;
   localparam int HW = gsps_pkg::HALF_W;

   logic [MW-1:0]            pend_ff, pend_in;
   logic [MW-1:0]            comm_ff, comm_in;
   logic [HW-1:0]            steps_ff, steps_in;
   logic [HW-1:0]            phase_ff, phase_in;
   logic                     level_ff, level_in;
   logic                     dir_ff, dir_in;
   logic                     slow_ff, slow_in;
   logic                     zreq_ff, zreq_in;
   gsps_pkg::zero_phase_type zp_ff, zp_in;

   // One item: command, then tick advance, then scheduling of the next train.
   always_comb begin
      logic          go_on;
      logic          launch;
      logic [HW-1:0] l_count;
      logic          l_dir;
      logic          l_slow;
      logic [HW-1:0] half;
      logic [HW-1:0] phase_inc;

      pend_in   = pend_ff;
      comm_in   = comm_ff;
      steps_in  = steps_ff;
      phase_in  = phase_ff;
      level_in  = level_ff;
      dir_in    = dir_ff;
      slow_in   = slow_ff;
      zreq_in   = zreq_ff;
      zp_in     = zp_ff;
      go_on     = 1'b0;
      launch    = 1'b0;
      l_count   = '0;
      l_dir     = 1'b0;
      l_slow    = 1'b0;
      half      = slow_ff ? cfg.half_slow : cfg.half_fast;
      phase_inc = phase_ff + 1'b1;

      if (op_valid) begin
         // Command first.
         if (op.kind == gsps_pkg::OP_SET) begin
            pend_in = op.target;
         end else if (op.kind == gsps_pkg::OP_ZERO) begin
            zreq_in = 1'b1;
         end

         // A tick moves a running pulse train on by one.
         if (op.kind == gsps_pkg::OP_TICK && steps_ff != '0) begin
            if (phase_inc >= half) begin
               phase_in = '0;
               if (level_ff) begin
                  level_in = 1'b0;
                  steps_in = steps_ff - 1'b1;
               end else begin
                  level_in = 1'b1;
               end
            end else begin
               phase_in = phase_inc;
            end
         end

         // With no train running, start the next zero phase, a zero sequence or a move.
         if (op.kind != gsps_pkg::OP_NOP && steps_in == '0) begin
            unique case (zp_ff)
               gsps_pkg::ZP_FWD: begin
                  zp_in   = gsps_pkg::ZP_BACK;
                  launch  = 1'b1;
                  l_count = HW'(cfg.max_steps);
                  l_dir   = 1'b1;
               end
               gsps_pkg::ZP_BACK: begin
                  if (cfg.back_off != '0) begin
                     zp_in   = gsps_pkg::ZP_OFF;
                     launch  = 1'b1;
                     l_count = HW'(cfg.back_off);
                     l_dir   = 1'b1;
                     l_slow  = 1'b1;
                  end else begin
                     zp_in = gsps_pkg::ZP_NONE;
                     go_on = 1'b1;
                  end
               end
               gsps_pkg::ZP_OFF: begin
                  zp_in   = gsps_pkg::ZP_NONE;
                  slow_in = 1'b0;
                  go_on   = 1'b1;
               end
               gsps_pkg::ZP_NONE: begin
                  go_on = 1'b1;
               end
               default: begin
                  zp_in = gsps_pkg::ZP_NONE;
                  go_on = 1'b1;
               end
            endcase

            // A waiting zero request comes before a pending move.
            if (go_on) begin
               if (zreq_ff || zreq_in) begin
                  zreq_in = 1'b0;
                  pend_in = '0;
                  comm_in = '0;
                  zp_in   = gsps_pkg::ZP_FWD;
                  launch  = 1'b1;
                  l_count = HW'(cfg.max_steps);
               end else if (pend_in != comm_ff) begin
                  launch  = 1'b1;
                  comm_in = pend_in;
                  if (pend_in > comm_ff) begin
                     l_count = HW'(pend_in - comm_ff);
                  end else begin
                     l_count = HW'(comm_ff - pend_in);
                     l_dir   = 1'b1;
                  end
               end
            end
         end

         // A launch raises the step pin at once unless there is nothing to do.
         if (launch) begin
            steps_in = l_count;
            dir_in   = l_dir;
            slow_in  = l_slow;
            phase_in = '0;
            level_in = (l_count != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         comm_ff  <= '0;
         steps_ff <= '0;
         phase_ff <= '0;
         level_ff <= 1'b0;
         dir_ff   <= 1'b0;
         slow_ff  <= 1'b0;
         zreq_ff  <= 1'b0;
         zp_ff    <= gsps_pkg::ZP_NONE;
      end else begin
         pend_ff  <= pend_in;
         comm_ff  <= comm_in;
         steps_ff <= steps_in;
         phase_ff <= phase_in;
         level_ff <= level_in;
         dir_ff   <= dir_in;
         slow_ff  <= slow_in;
         zreq_ff  <= zreq_in;
         zp_ff    <= zp_in;
      end
   end

   // Result reflects the state after this item.
   always_comb begin
      rsp.step_level = level_in;
      rsp.dir_level  = dir_in;
      rsp.zeroing    = (zp_in != gsps_pkg::ZP_NONE);
      rsp.busy_res   = (steps_in != '0) || (zp_in != gsps_pkg::ZP_NONE);
      rsp.position   = comm_in;
   end

endmodule

>>> rtl/gauge_stepper_pulse_sequencer.sv
// Gauge stepper pulse sequencer: one result item for every accepted command.
// A command passes through the command queue and the back end into the result queue.
// Throughput: one command per cycle while the result queue has room.
// Reset (synchronous, active high) empties both queues, clears the motion state and
// loads the register defaults. Depends on gsps_pkg, gsps_front, gsps_fifo, gsps_back.
module gauge_stepper_pulse_sequencer #(
   parameter int CMD_DEPTH = gsps_pkg::CMD_DEPTH_DEF,
   parameter int RSP_DEPTH = gsps_pkg::RSP_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Command side.
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [1:0]                           req_cmd,
   input  logic signed [15:0]                   req_target,
   // Result side.
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic                                 rsp_step_level,
   output logic                                 rsp_dir_level,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_zeroing,
   output logic [gsps_pkg::MAX_STEPS_W-1:0]     rsp_position,
   // Register writes.
   input  logic                                 csr_wr_en,
   input  logic [gsps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gsps_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int OP_W  = $bits(gsps_pkg::op_type);
   localparam int RSP_W = $bits(gsps_pkg::rsp_type);

   gsps_pkg::cfg_type cfg_ff, cfg_in;
   gsps_pkg::op_type  front_op, back_op;
   gsps_pkg::rsp_type back_rsp, head_rsp;
   logic              op_empty;
   logic              rsp_full;
   logic              step_go;

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            gsps_pkg::CSR_MAX_STEPS:
               cfg_in.max_steps = csr_wdata[gsps_pkg::MAX_STEPS_W-1:0];
            gsps_pkg::CSR_HALF_FAST:
               cfg_in.half_fast = csr_wdata;
            gsps_pkg::CSR_HALF_SLOW:
               cfg_in.half_slow = csr_wdata;
            gsps_pkg::CSR_BACK_OFF:
               cfg_in.back_off  = csr_wdata[gsps_pkg::BACK_OFF_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_steps <= gsps_pkg::MAX_STEPS_RST;
         cfg_ff.half_fast <= gsps_pkg::HALF_FAST_RST;
         cfg_ff.half_slow <= gsps_pkg::HALF_SLOW_RST;
         cfg_ff.back_off  <= gsps_pkg::BACK_OFF_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Decode and clamp on entry.
   gsps_front u_front (
      .cmd       (req_cmd),
      .target    (req_target),
      .max_steps (cfg_ff.max_steps),
      .op        (front_op)
   );

   // Queue of decoded commands between front and back end.
   gsps_fifo #(
      .DEPTH (CMD_DEPTH),
      .WIDTH (OP_W)
   ) u_op_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (front_op),
      .full  (req_full),
      .pop   (step_go),
      .rdata (back_op),
      .empty (op_empty)
   );

   // The back end steps whenever a command waits and there is room for its result.
   assign step_go = !op_empty && !rsp_full;

   gsps_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .op_valid (step_go),
      .op       (back_op),
      .rsp      (back_rsp)
   );

   // Results wait here for the consumer.
   gsps_fifo #(
      .DEPTH (RSP_DEPTH),
      .WIDTH (RSP_W)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (step_go),
      .wdata (back_rsp),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (head_rsp),
      .empty (rsp_empty)
   );

   assign rsp_step_level = head_rsp.step_level;
   assign rsp_dir_level  = head_rsp.dir_level;
   assign rsp_busy_res   = head_rsp.busy_res;
   assign rsp_zeroing    = head_rsp.zeroing;
   assign rsp_position   = head_rsp.position;

endmodule

>>> rtl/gsps_checker.sv
// Port-level checks for the gauge stepper pulse sequencer, bound to the top level.
// Depends on gsps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gsps_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_empty,
   input logic                             rsp_pop,
   input logic                             rsp_step_level,
   input logic                             rsp_dir_level,
   input logic                             rsp_busy_res,
   input logic                             rsp_zeroing,
   input logic [gsps_pkg::MAX_STEPS_W-1:0] rsp_position
);

   // Nothing is waiting to be taken right after reset.
   `GSPS_ASSERT_NEXT_ALWAYS(a_empty_after_reset, clock, reset, rsp_empty, "result after reset")

   // A zero sequence always counts as busy.
   `GSPS_ASSERT_IMPL(a_zero_busy, clock, reset, !rsp_empty && rsp_zeroing, rsp_busy_res, "zeroing while idle")

   // With no train running the step pin is low.
   `GSPS_ASSERT_IMPL(a_idle_low, clock, reset, !rsp_empty && !rsp_busy_res, !rsp_step_level, "step high while idle")

   // A result that is not taken stays as it was.
   `GSPS_ASSERT_NEXT(a_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable({rsp_step_level, rsp_dir_level, rsp_busy_res, rsp_zeroing, rsp_position}), "stalled result changed")

endmodule

bind gauge_stepper_pulse_sequencer gsps_checker u_gsps_checker (.*);

>>> test/tb_gauge_stepper_pulse_sequencer.sv
// Self-checking testbench for the gauge stepper pulse sequencer: directed and random commands.
// Depends on gsps_pkg and gauge_stepper_pulse_sequencer; predicts every result item itself.
module tb_gauge_stepper_pulse_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TIMEOUT_NS = 4_000_000;

   // Clock, reset and block ports.
   logic clock = 1'b0;
   logic reset;
   logic req_push;
   logic req_full;
   logic [1:0] req_cmd;
   logic signed [15:0] req_target;
   logic rsp_empty;
   logic rsp_pop;
   logic rsp_step_level;
   logic rsp_dir_level;
   logic rsp_busy_res;
   logic rsp_zeroing;
   logic [gsps_pkg::MAX_STEPS_W-1:0] rsp_position;
   logic csr_wr_en;
   logic [gsps_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [gsps_pkg::CSR_DATA_W-1:0] csr_wdata;

   // Idle rates of both sides, in percent of cycles.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   // Requests for a long hold-off on the result side; the receiver counts the cycles.
   int hold_len = 0;
   int hold_req_count = 0;
   int mismatch_count = 0;

   // Expected pin states, oldest first.
   gsps_pkg::rsp_type pin_state_q[$];

   // Register copy and motion state of the predictor.
   gsps_pkg::cfg_type cfg;
   logic [gsps_pkg::MAX_STEPS_W-1:0] pend_pos;
   logic [gsps_pkg::MAX_STEPS_W-1:0] commit_pos;
   logic [15:0] steps_rem;
   logic [15:0] phase_cnt;
   logic pin_level;
   logic dir_bit;
   logic slow_sel;
   gsps_pkg::zero_phase_type zero_stage;
   logic zero_pending;

   gauge_stepper_pulse_sequencer i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_cmd        (req_cmd),
      .req_target     (req_target),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_step_level (rsp_step_level),
      .rsp_dir_level  (rsp_dir_level),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_zeroing    (rsp_zeroing),
      .rsp_position   (rsp_position),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Free-running clock, 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Starts a pulse train; the step pin goes high at once unless it is empty.
   function automatic void start_train(input logic [15:0] count, input logic backward,
                                       input logic slow);
      steps_rem = count;
      dir_bit   = backward;
      slow_sel  = slow;
      phase_cnt = '0;
      pin_level = (count != 16'd0);
   endfunction

   // Applies one command to the predicted state and returns the pin state that follows.
   function automatic gsps_pkg::rsp_type next_pin_state(input logic [1:0] cmd,
                                                        input logic [15:0] raw);
      logic [gsps_pkg::MAX_STEPS_W-1:0] top;
      logic [15:0] half;
      logic fwd;
      gsps_pkg::rsp_type r;
      top = (cfg.max_steps != '0) ? cfg.max_steps - 15'd1 : '0;

      // The command itself: a clamped target or a zeroing request.
      if (cmd == gsps_pkg::CMD_SET) begin
         if (raw[15]) pend_pos = '0;
         else if (raw > {1'b0, top}) pend_pos = top;
         else pend_pos = raw[14:0];
      end else if (cmd == gsps_pkg::CMD_ZERO) begin
         zero_pending = 1'b1;
      end

      // A tick moves a running train on by one phase count.
      if (cmd == gsps_pkg::CMD_TICK && steps_rem != 16'd0) begin
         half = slow_sel ? cfg.half_slow : cfg.half_fast;
         phase_cnt = phase_cnt + 16'd1;
         if (phase_cnt >= half) begin
            phase_cnt = '0;
            if (pin_level) begin
               pin_level = 1'b0;
               steps_rem = steps_rem - 16'd1;
            end else begin
               pin_level = 1'b1;
            end
         end
      end

      // With no train running, launch the next zeroing stage, a zero or a pending move.
      if (cmd != gsps_pkg::OP_NOP && steps_rem == 16'd0) begin
         if (zero_stage == gsps_pkg::ZP_FWD) begin
            zero_stage = gsps_pkg::ZP_BACK;
            start_train({1'b0, cfg.max_steps}, 1'b1, 1'b0);
         end else if (zero_stage == gsps_pkg::ZP_BACK && cfg.back_off != '0) begin
            zero_stage = gsps_pkg::ZP_OFF;
            start_train({8'd0, cfg.back_off}, 1'b1, 1'b1);
         end else begin
            if (zero_stage == gsps_pkg::ZP_OFF) slow_sel = 1'b0;
            zero_stage = gsps_pkg::ZP_NONE;
            if (zero_pending) begin
               zero_pending = 1'b0;
               pend_pos     = '0;
               commit_pos   = '0;
               zero_stage   = gsps_pkg::ZP_FWD;
               start_train({1'b0, cfg.max_steps}, 1'b0, 1'b0);
            end else if (pend_pos != commit_pos) begin
               fwd = pend_pos > commit_pos;
               start_train(fwd ? {1'b0, pend_pos - commit_pos} : {1'b0, commit_pos - pend_pos},
                           !fwd, 1'b0);
               commit_pos = pend_pos;
            end
         end
      end

      r.step_level = pin_level;
      r.dir_level  = dir_bit;
      r.busy_res   = (steps_rem != 16'd0) || (zero_stage != gsps_pkg::ZP_NONE);
      r.zeroing    = (zero_stage != gsps_pkg::ZP_NONE);
      r.position   = commit_pos;
      return r;
   endfunction

   // Offers one command, idling at random first, and records its prediction on transfer.
   task automatic send_item(input logic [1:0] cmd, input logic [15:0] raw);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push   <= 1'b1;
      req_cmd    <= cmd;
      req_target <= raw;
      do @(posedge clock); while (req_full);
      pin_state_q.push_back(next_pin_state(cmd, raw));
   endtask

   // Stops offering and waits until every expected result has been taken.
   task automatic wait_drained();
      req_push <= 1'b0;
      while (pin_state_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes all four registers back to back, with the block idle.
   task automatic set_config(input logic [14:0] ms, input logic [15:0] hf,
                             input logic [15:0] hs, input logic [7:0] bo);
      csr_wr_en <= 1'b1;
      csr_index <= gsps_pkg::CSR_MAX_STEPS;
      csr_wdata <= {1'b0, ms};
      @(posedge clock);
      csr_index <= gsps_pkg::CSR_HALF_FAST;
      csr_wdata <= hf;
      @(posedge clock);
      csr_index <= gsps_pkg::CSR_HALF_SLOW;
      csr_wdata <= hs;
      @(posedge clock);
      csr_index <= gsps_pkg::CSR_BACK_OFF;
      csr_wdata <= {8'd0, bo};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg.max_steps = ms;
      cfg.half_fast = hf;
      cfg.half_slow = hs;
      cfg.back_off  = bo;
   endtask

   // Random commands, mostly ticks so that moves and zero sequences run to their end.
   // Ignored commands are sent too but are not counted.
   task automatic run_random(input int count);
      int sent;
      int pick;
      logic [1:0] cmd;
      logic [15:0] raw;
      sent = 0;
      while (sent < count) begin
         pick = int'($urandom_range(99));
         raw  = 16'($urandom());
         if (pick < 70) begin
            cmd = gsps_pkg::CMD_TICK;
         end else if (pick < 90) begin
            cmd = gsps_pkg::CMD_SET;
            if ($urandom_range(3) != 0) raw = 16'($urandom_range(int'(cfg.max_steps) + 1));
         end else if (pick < 97) begin
            cmd = gsps_pkg::CMD_ZERO;
         end else begin
            cmd = gsps_pkg::OP_NOP;
         end
         send_item(cmd, raw);
         if (cmd != gsps_pkg::OP_NOP) sent++;
      end
   endtask

   // Register defaults: ignored command, tick, negative target and a target equal to the position.
   task automatic test_reset_defaults();
      send_item(gsps_pkg::OP_NOP, 16'h1234);
      send_item(gsps_pkg::CMD_TICK, 16'h0000);
      send_item(gsps_pkg::CMD_SET, 16'h8000);
      send_item(gsps_pkg::CMD_SET, 16'h0000);
      wait_drained();
   endtask

   // Zero full scale and zero half periods: the sweeps are empty and every target clamps to 0.
   task automatic test_zero_scale();
      set_config(15'd0, 16'd0, 16'd0, 8'd0);
      send_item(gsps_pkg::CMD_ZERO, 16'hFFFF);
      send_item(gsps_pkg::CMD_TICK, 16'h0000);
      send_item(gsps_pkg::CMD_TICK, 16'h7FFF);
      send_item(gsps_pkg::CMD_SET, 16'd100);
      wait_drained();
   endtask

   // A target equal to full scale clamps one below it; the move ends before the zero arrives,
   // and a new target sent during the zero sequence is carried out once it ends.
   task automatic test_queued_zero();
      set_config(15'd2, 16'd1, 16'd2, 8'd1);
      send_item(gsps_pkg::CMD_SET, 16'd2);
      send_item(gsps_pkg::CMD_TICK, 16'd0);
      send_item(gsps_pkg::CMD_ZERO, 16'd0);
      send_item(gsps_pkg::CMD_SET, 16'd5);
      repeat (16) send_item(gsps_pkg::CMD_TICK, 16'($urandom()));
      wait_drained();
   endtask

   // One phase of random traffic with its own idle rates and register setting.
   task automatic test_random_phase(input int s_pct, input int r_pct, input int count,
                                    input logic [14:0] ms, input logic [15:0] hf,
                                    input logic [15:0] hs, input logic [7:0] bo);
      set_config(ms, hf, hs, bo);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      run_random(count);
      wait_drained();
   endtask

   // The result side refuses to pop for a long stretch while commands keep coming,
   // so both queues fill and the command side stalls; then the sender waits for all results.
   task automatic test_input_stall();
      set_config(15'd1, 16'd1, 16'd1, 8'd3);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_len      = 300;
      hold_req_count++;
      run_random(40);
      wait_drained();
   endtask

   // Largest register values: long sweeps and half periods at the top of the counter range.
   task automatic test_full_scale();
      set_config(15'h7FFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_item(gsps_pkg::CMD_SET, 16'h7FFF);
      run_random(40);
      send_item(gsps_pkg::CMD_ZERO, 16'h0000);
      wait_drained();
   endtask

   // Result side: pops at random or holds off, and checks every transfer.
   initial begin
      gsps_pkg::rsp_type exp_state;
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            if (pin_state_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: step %b dir %b busy %b zeroing %b position %0d",
                           rsp_step_level, rsp_dir_level, rsp_busy_res, rsp_zeroing,
                           rsp_position);
            end else begin
               exp_state = pin_state_q.pop_front();
               if (rsp_step_level !== exp_state.step_level ||
                   rsp_dir_level  !== exp_state.dir_level  ||
                   rsp_busy_res   !== exp_state.busy_res   ||
                   rsp_zeroing    !== exp_state.zeroing    ||
                   rsp_position   !== exp_state.position) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected %b %b %b %b %0d, got %b %b %b %b %0d",
                              exp_state.step_level, exp_state.dir_level, exp_state.busy_res,
                              exp_state.zeroing, exp_state.position, rsp_step_level,
                              rsp_dir_level, rsp_busy_res, rsp_zeroing, rsp_position);
               end
            end
         end
         // A new hold-off request starts a fresh count of refused cycles.
         if (hold_seen != hold_req_count) begin
            hold_seen = hold_req_count;
            hold_left = hold_len;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Run time limit.
   initial begin
      #(TIMEOUT_NS);
      $display("gauge_stepper_pulse_sequencer regression: fail");
      $finish;
   end

   // Test sequence.
   initial begin
      reset      <= 1'b1;
      req_push   <= 1'b0;
      req_cmd    <= gsps_pkg::CMD_TICK;
      req_target <= '0;
      csr_wr_en  <= 1'b0;
      csr_index  <= gsps_pkg::CSR_MAX_STEPS;
      csr_wdata  <= '0;
      cfg.max_steps = gsps_pkg::MAX_STEPS_RST;
      cfg.half_fast = gsps_pkg::HALF_FAST_RST;
      cfg.half_slow = gsps_pkg::HALF_SLOW_RST;
      cfg.back_off  = gsps_pkg::BACK_OFF_RST;
      pend_pos     = '0;
      commit_pos   = '0;
      steps_rem    = '0;
      phase_cnt    = '0;
      pin_level    = 1'b0;
      dir_bit      = 1'b0;
      slow_sel     = 1'b0;
      zero_stage   = gsps_pkg::ZP_NONE;
      zero_pending = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_zero_scale();
      test_queued_zero();
      test_random_phase(30, 80, 330, 15'($urandom_range(2, 16)), 16'($urandom_range(1, 3)),
                        16'($urandom_range(1, 4)), 8'($urandom_range(1, 4)));
      test_input_stall();
      test_random_phase(80, 30, 330, 15'($urandom_range(1, 8)), 16'($urandom_range(0, 2)),
                        16'($urandom_range(0, 2)), 8'd0);
      test_random_phase(0, 0, 330, 15'($urandom_range(2, 24)), 16'd1, 16'd1, 8'hFF);
      test_full_scale();

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pin_state_q.size() == 0) begin
         $display("gauge_stepper_pulse_sequencer regression: pass");
      end else begin
         $display("gauge_stepper_pulse_sequencer regression: fail");
      end
      $finish;
   end

endmodule
